FILE: src/thsd_pkg.sv
`timescale 1ns / 1ps

package thsd_pkg;

   localparam int TEMP_W     = 13;
   localparam int SETPOINT_W = 12;
   localparam int REG_PER_W  = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int DIFF_W     = 14;

   typedef enum logic [2:0] {
      MODE_STOP  = 3'd0,
      MODE_HEAT  = 3'd1,
      MODE_VLOW  = 3'd2,
      MODE_VMED  = 3'd3,
      MODE_VHIGH = 3'd4
   } mode_type;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_TICK   = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT   = 3'd0,
      CSR_SLOW_PER   = 3'd1,
      CSR_MEDIUM_PER = 3'd2,
      CSR_FAST_PER   = 3'd3,
      CSR_LAMP_INV   = 3'd4
   } csr_idx_type;

   localparam logic signed [SETPOINT_W-1:0] SETPOINT_RST   = 12'sd250;
   localparam logic [REG_PER_W-1:0]         SLOW_PER_RST   = 16'd10000;
   localparam logic [REG_PER_W-1:0]         MEDIUM_PER_RST = 16'd3333;
   localparam logic [REG_PER_W-1:0]         FAST_PER_RST   = 16'd1667;

   localparam logic signed [DIFF_W-1:0] BAND_HEAT = -14'sd10;
   localparam logic signed [DIFF_W-1:0] BAND_STOP = 14'sd10;
   localparam logic signed [DIFF_W-1:0] BAND_VLOW = 14'sd30;
   localparam logic signed [DIFF_W-1:0] BAND_VMED = 14'sd50;

   typedef struct packed {
      logic signed [SETPOINT_W-1:0] setpoint;
      logic [REG_PER_W-1:0]         slow_period;
      logic [REG_PER_W-1:0]         medium_period;
      logic [REG_PER_W-1:0]         fast_period;
      logic                         relay_invert;
   } cfg_type;

   typedef struct packed {
      logic [3:0] coils;
      logic       lamp_on;
      logic       relay_level;
      logic [2:0] mode;
      logic [2:0] phase;
   } rsp_payload_type;

   function automatic logic [3:0] half_step(input logic [2:0] ph);
      logic [3:0] pat;
      case (ph)
         3'd0:    pat = 4'h8;
         3'd1:    pat = 4'hA;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'h5;
         3'd6:    pat = 4'h1;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

endpackage

FILE: src/thsd_if.sv
`timescale 1ns / 1ps

interface thsd_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic signed [thsd_pkg::TEMP_W-1:0]  temperature;

   modport source (output valid, output req_type, output temperature, input ready);
   modport sink   (input valid, input req_type, input temperature, output ready);
endinterface

interface thsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] coils;
   logic       lamp_on;
   logic       relay_level;
   logic [2:0] mode;
   logic [2:0] phase;

   modport source (output valid, output coils, output lamp_on, output relay_level,
                   output mode, output phase, input ready);
   modport sink   (input valid, input coils, input lamp_on, input relay_level,
                   input mode, input phase, output ready);
endinterface

FILE: src/thsd_csr.sv
`timescale 1ns / 1ps

module thsd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [thsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [thsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output thsd_pkg::cfg_type                cfg
);
   import thsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SETPOINT:   cfg_in.setpoint      = signed'(csr_wdata[SETPOINT_W-1:0]);
            CSR_SLOW_PER:   cfg_in.slow_period   = csr_wdata[REG_PER_W-1:0];
            CSR_MEDIUM_PER: cfg_in.medium_period = csr_wdata[REG_PER_W-1:0];
            CSR_FAST_PER:   cfg_in.fast_period   = csr_wdata[REG_PER_W-1:0];
            CSR_LAMP_INV:   cfg_in.relay_invert  = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint      <= SETPOINT_RST;
         cfg_ff.slow_period   <= SLOW_PER_RST;
         cfg_ff.medium_period <= MEDIUM_PER_RST;
         cfg_ff.fast_period   <= FAST_PER_RST;
         cfg_ff.relay_invert  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/thsd_core.sv
`timescale 1ns / 1ps

module thsd_core #(
   parameter int PERIOD_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  thsd_pkg::cfg_type                   cfg,
   input  logic                                step,
   input  logic                                req_type,
   input  logic signed [thsd_pkg::TEMP_W-1:0]  temperature,
   output thsd_pkg::rsp_payload_type           result
);
   import thsd_pkg::*;

   localparam int CMP_W = ((PERIOD_WIDTH > REG_PER_W) ? PERIOD_WIDTH : REG_PER_W) + 1;
   localparam logic [CMP_W-1:0] CAP = CMP_W'(1) << PERIOD_WIDTH;

   mode_type                  mode_ff, mode_in, sample_mode;
   logic [2:0]                phase_ff, phase_in;
   logic [PERIOD_WIDTH-1:0]   count_ff, count_in;
   logic signed [DIFF_W-1:0]  diff;
   logic [REG_PER_W-1:0]      per_sel;
   logic [CMP_W-1:0]          per_eff;
   logic [CMP_W-1:0]          count_next;
   logic                      wrap;
   logic                      lamp;

   always_comb begin
      diff = DIFF_W'(temperature) - DIFF_W'(cfg.setpoint);
      if (diff < BAND_HEAT) begin
         sample_mode = MODE_HEAT;
      end else if (diff <= BAND_STOP) begin
         sample_mode = MODE_STOP;
      end else if (diff < BAND_VLOW) begin
         sample_mode = MODE_VLOW;
      end else if (diff <= BAND_VMED) begin
         sample_mode = MODE_VMED;
      end else begin
         sample_mode = MODE_VHIGH;
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_VMED:  per_sel = cfg.medium_period;
         MODE_VHIGH: per_sel = cfg.fast_period;
         default:    per_sel = cfg.slow_period;
      endcase
      per_eff = CMP_W'(per_sel);
      if (per_sel == '0) begin
         per_eff = CMP_W'(1);
      end
      if (per_eff > CAP) begin
         per_eff = CAP;
      end
      count_next = CMP_W'(count_ff) + CMP_W'(1);
      wrap       = (count_next >= per_eff);
   end

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      if (req_type == REQ_SAMPLE) begin
         if (sample_mode != mode_ff) begin
            mode_in  = sample_mode;
            count_in = '0;
         end
      end else if (mode_ff != MODE_STOP) begin
         if (wrap) begin
            count_in = '0;
            phase_in = (mode_ff == MODE_HEAT) ? phase_ff + 3'd1 : phase_ff - 3'd1;
         end else begin
            count_in = count_next[PERIOD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STOP;
         phase_ff <= 3'd0;
         count_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      lamp               = (mode_in == MODE_HEAT);
      result.coils       = (mode_in == MODE_STOP) ? 4'h0 : half_step(phase_in);
      result.lamp_on     = lamp;
      result.relay_level = lamp ^ cfg.relay_invert;
      result.mode        = mode_in;
      result.phase       = phase_in;
   end

endmodule

FILE: src/thsd_outbuf.sv
`timescale 1ns / 1ps

module thsd_outbuf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  thsd_pkg::rsp_payload_type   push_data,
   output logic                        can_push,
   thsd_rsp_if.source                  rsp
);
   import thsd_pkg::*;

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   rsp_payload_type  out_data_ff, out_data_in;
   rsp_payload_type  skid_data_ff, skid_data_in;
   logic             drain;

   // skid entry only fills when the output register is held
   always_comb begin
      drain         = !out_valid_ff || rsp.ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (drain) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign can_push        = !skid_valid_ff;
   assign rsp.valid       = out_valid_ff;
   assign rsp.coils       = out_data_ff.coils;
   assign rsp.lamp_on     = out_data_ff.lamp_on;
   assign rsp.relay_level = out_data_ff.relay_level;
   assign rsp.mode        = out_data_ff.mode;
   assign rsp.phase       = out_data_ff.phase;

endmodule

FILE: src/thermostat_stepper_drive_top.sv
`timescale 1ns / 1ps
// Thermostat stepper drive.
// req_ch takes items: a temperature sample (req_type 0) picks one of five
// modes from the setpoint bands; a tick (req_type 1) outside stop mode
// advances the counter and moves the half-step phase once per mode period.
// rsp_ch gives one item per request: coils, lamp, relay level, mode, phase.
// csr_* writes setpoint, the three periods and the relay inversion, one
// register per cycle; the user must write only while no item is in flight.
// A result is offered the cycle after its request is taken when the
// output register is free; behind a stalled result it waits in the skid.
// Throughput: one item per cycle while req_ch is ready; state update,
// band and period compares all sit between the state and output registers.
// A two-entry output stage (output register plus skid entry) keeps req_ch
// ready while one result waits; ready drops only once both are full.
// Reset: mode stop, phase 0, counter 0, registers to their defaults,
// output stage empty.
module thermostat_stepper_drive_top #(
   parameter int PERIOD_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   thsd_req_if.sink                         req_ch,
   thsd_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [thsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [thsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import thsd_pkg::*;

   cfg_type          cfg;
   rsp_payload_type  result;
   logic             can_push;
   logic             step;

   assign req_ch.ready = can_push;
   assign step         = req_ch.valid && can_push;

   thsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   thsd_core #(
      .PERIOD_WIDTH (PERIOD_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (step),
      .req_type    (req_ch.req_type),
      .temperature (req_ch.temperature),
      .result      (result)
   );

   thsd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (result),
      .can_push  (can_push),
      .rsp       (rsp_ch)
   );

endmodule

FILE: src/thsd_checker.sv
`timescale 1ns / 1ps

module thsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_coils,
   input logic       rsp_lamp_on,
   input logic [2:0] rsp_mode,
   input logic [2:0] rsp_phase
);
   import thsd_pkg::*;

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coils) && $stable(rsp_mode)
         && $stable(rsp_phase) && $stable(rsp_lamp_on))
      else $error("stalled item changed");

   a_stop_coils: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == MODE_STOP |-> rsp_coils == 4'h0)
      else $error("coils driven in stop");

   a_coil_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != MODE_STOP |-> rsp_coils == half_step(rsp_phase))
      else $error("coils do not match phase");

   a_lamp_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lamp_on == (rsp_mode == MODE_HEAT))
      else $error("lamp does not follow heat mode");

endmodule

bind thermostat_stepper_drive_top thsd_checker u_thsd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_coils   (rsp_ch.coils),
   .rsp_lamp_on (rsp_ch.lamp_on),
   .rsp_mode    (rsp_ch.mode),
   .rsp_phase   (rsp_ch.phase)
);
